@@ design/htw_pkg.sv @@
// shared types and constants for the hashed timing wheel
`timescale 1ns / 1ps
package htw_pkg;

  // action codes
  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned TOK_ID_W    = 6;   // covers up to 64 timers
  localparam int unsigned SLOT_W      = 9;   // covers up to 512 slots

  // timeout/2000 = (timeout>>4)/125, reciprocal of 125 scaled by 2^23
  localparam logic [16:0] RECIP_125 = 17'd67109;
  localparam int unsigned RECIP_SH  = 23;

  typedef enum logic [2:0] {
    CELL_NOP    = 3'd0,
    CELL_CREATE = 3'd1,
    CELL_FILE   = 3'd2,
    CELL_STOP   = 3'd3,
    CELL_EXPIRE = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [TOK_ID_W-1:0] id;
    logic [SLOT_W-1:0]   slot;
    logic [15:0]         kind;
    logic [31:0]         tag;
    logic [SLOT_W-1:0]   cur_slot;
    logic [31:0]         stamp_ctr;
  } cell_cmd_t;

  typedef struct packed {
    logic                valid;
    logic [31:0]         age;
    logic [TOK_ID_W-1:0] id;
    logic [15:0]         kind;
    logic [31:0]         tag;
  } token_t;

  typedef struct packed {
    logic        expired;
    logic [4:0]  expired_id;
    logic [15:0] expired_type;
    logic [31:0] expired_tag;
    logic        status;
    logic        last;
  } result_t;

endpackage

@@ design/htw_if.sv @@
// handshake channels for commands and results
`timescale 1ns / 1ps
interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [4:0]  timer_id;
  logic [31:0] timeout_ms;
  logic [15:0] timer_type;
  logic [31:0] user_tag;
  modport source (output valid, action, timer_id, timeout_ms, timer_type, user_tag,
                  input ready);
  modport sink (input valid, action, timer_id, timeout_ms, timer_type, user_tag,
                output ready);
endinterface

interface htw_out_if;
  logic        valid;
  logic        ready;
  logic        expired;
  logic [4:0]  expired_id;
  logic [15:0] expired_type;
  logic [31:0] expired_tag;
  logic        status;
  logic        last;
  modport source (output valid, expired, expired_id, expired_type, expired_tag, status,
                  last, input ready);
  modport sink (input valid, expired, expired_id, expired_type, expired_tag, status,
                last, output ready);
endinterface

@@ design/htw_cell.sv @@
// one timer entry of the chain, passing the best due timer to its neighbor
`timescale 1ns / 1ps
module htw_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  htw_pkg::cell_cmd_t cmd_i,
  input  htw_pkg::token_t    tok_i,
  output htw_pkg::token_t    tok_o,
  output logic               active_o
);
  import htw_pkg::*;

  logic              active_q, active_d;
  logic [SLOT_W-1:0] slot_q;
  logic [15:0]       kind_q;
  logic [31:0]       tag_q;
  logic [31:0]       stamp_q;
  token_t            tok_q, tok_d;
  logic              hit;
  logic              due;
  logic [31:0]       age;

  assign hit = (cmd_i.id == TOK_ID_W'(INDEX));
  assign due = active_q && (slot_q == cmd_i.cur_slot);
  assign age = cmd_i.stamp_ctr - stamp_q;

  always_comb begin
    active_d = active_q;
    if (hit) begin
      case (cmd_i.op)
        CELL_CREATE: active_d = 1'b0;
        CELL_FILE:   active_d = 1'b1;
        CELL_STOP:   active_d = 1'b0;
        CELL_EXPIRE: active_d = 1'b0;
        default:     active_d = active_q;
      endcase
    end
  end

  // lower index wins a tie since the incoming word is kept on equal age
  always_comb begin
    tok_d = tok_i;
    if (due && (!tok_i.valid || age < tok_i.age)) begin
      tok_d.valid = 1'b1;
      tok_d.age   = age;
      tok_d.id    = TOK_ID_W'(INDEX);
      tok_d.kind  = kind_q;
      tok_d.tag   = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && cmd_i.op == CELL_CREATE) begin
      kind_q <= cmd_i.kind;
      tag_q  <= cmd_i.tag;
    end
    if (hit && cmd_i.op == CELL_FILE) begin
      slot_q  <= cmd_i.slot;
      stamp_q <= cmd_i.stamp_ctr;
    end
  end

  assign tok_o    = tok_q;
  assign active_o = active_q;

endmodule

@@ design/hashed_timing_wheel_unit.sv @@
// timing wheel top level: command sequencer, slot arithmetic and the timer cell chain
// create/start/restart/stop: an accepted word goes through CALC and APPLY before its result word, one command at a time
// tick: one full scan of the cell chain per expired timer plus one final scan, with the
//   best-timer word walking the cell chain one cell per cycle
// next word is accepted once the sequencer is back idle; a result may still wait at the output
// reset (async, active low) clears current slot, stamp counter and all active flags
`timescale 1ns / 1ps
module hashed_timing_wheel_unit #(
  parameter int unsigned NUM_TIMERS  = 32,
  parameter int unsigned WHEEL_SLOTS = 300
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htw_in_if.sink     in_i,
  htw_out_if.source  out_o
);
  import htw_pkg::*;

  localparam int unsigned CNT_W     = $clog2(NUM_TIMERS + 2);
  localparam logic [31:0] CLAMP_LIM = 32'(2000 * WHEEL_SLOTS);
  localparam logic [9:0]  CLAMP_SLOTS = 10'(WHEEL_SLOTS - 2);
  localparam logic [10:0] W_11        = 11'(WHEEL_SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [31:0]       stamp_cnt_q, stamp_cnt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [5:0]        n_q, n_d;
  result_t           pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [2:0]  act_q;
  logic [4:0]  id_q;
  logic [31:0] tmo_q;
  logic [15:0] kind_q;
  logic [31:0] tag_q;
  logic        clamp_q;
  logic [8:0]  quo_q;
  logic [32:0] prod;

  logic              accept;
  logic              out_free;
  logic              valid_id;
  logic              id_active;
  logic [9:0]        slots;
  logic [10:0]       slot_sum;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] next_slot;
  cell_cmd_t         cmd;
  token_t            chain [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] active_vec;
  token_t            win;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    htw_cell #(.INDEX(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1]),
      .active_o (active_vec[g])
    );
  end

  assign win = chain[NUM_TIMERS];

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign valid_id = (32'(id_q) < NUM_TIMERS);

  always_comb begin
    id_active = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (32'(id_q) == i && active_vec[i]) id_active = 1'b1;
    end
  end

  // below the clamp limit the timeout fits in 20 bits
  assign prod = {17'd0, tmo_q[19:4]} * {16'd0, RECIP_125};

  always_comb begin
    if (clamp_q) slots = CLAMP_SLOTS;
    else if (quo_q < 9'd2) slots = 10'd3;
    else slots = {1'b0, quo_q} + 10'd1;
  end

  assign slot_sum = {2'b00, cur_slot_q} + {1'b0, slots};
  assign new_slot = (slot_sum >= W_11) ? SLOT_W'(slot_sum - W_11) : SLOT_W'(slot_sum);
  assign next_slot = (32'(cur_slot_q) + 1 == WHEEL_SLOTS) ? '0 : cur_slot_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    cur_slot_d   = cur_slot_q;
    stamp_cnt_d  = stamp_cnt_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    cmd.op        = CELL_NOP;
    cmd.id        = {1'b0, id_q};
    cmd.slot      = new_slot;
    cmd.kind      = kind_q;
    cmd.tag       = tag_q;
    cmd.cur_slot  = cur_slot_q;
    cmd.stamp_ctr = stamp_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.action == ACT_TICK) begin
            cur_slot_d   = next_slot;
            n_d          = '0;
            pend_valid_d = 1'b0;
            cnt_d        = '0;
            state_d      = ST_SCAN;
          end else begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: state_d = ST_APPLY;
      ST_APPLY: begin
        if (out_free) begin
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          if (valid_id) begin
            case (act_q)
              ACT_CREATE: cmd.op = CELL_CREATE;
              ACT_START, ACT_RESTART: begin
                cmd.op      = CELL_FILE;
                stamp_cnt_d = stamp_cnt_q + 32'd1;
              end
              ACT_STOP: begin
                if (id_active) cmd.op = CELL_STOP;
                else out_d.status = 1'b1;
              end
              default: cmd.op = CELL_NOP;
            endcase
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == NUM_TIMERS) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (win.valid && 32'(n_q) < MAX_RESULTS) begin
          // the held word goes out only once a later one is known or the tick ends
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d.expired      = 1'b1;
            pend_d.expired_id   = win.id[4:0];
            pend_d.expired_type = win.kind;
            pend_d.expired_tag  = win.tag;
            pend_d.status       = 1'b0;
            pend_d.last         = 1'b0;
            pend_valid_d        = 1'b1;
            cmd.op              = CELL_EXPIRE;
            cmd.id              = win.id;
            n_d                 = n_q + 6'd1;
            cnt_d               = '0;
            state_d             = ST_SCAN;
          end
        end else if (out_free) begin
          if (pend_valid_q) begin
            out_d = pend_q;
          end else begin
            out_d = '0;
          end
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_slot_q   <= '0;
      stamp_cnt_q  <= '0;
      cnt_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_slot_q   <= cur_slot_d;
      stamp_cnt_q  <= stamp_cnt_d;
      cnt_q        <= cnt_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (accept) begin
      act_q  <= in_i.action;
      id_q   <= in_i.timer_id;
      tmo_q  <= in_i.timeout_ms;
      kind_q <= in_i.timer_type;
      tag_q  <= in_i.user_tag;
    end
    if (state_q == ST_CALC) begin
      clamp_q <= (tmo_q >= CLAMP_LIM);
      quo_q   <= prod[RECIP_SH+8:RECIP_SH];
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.expired      = out_q.expired;
  assign out_o.expired_id   = out_q.expired_id;
  assign out_o.expired_type = out_q.expired_type;
  assign out_o.expired_tag  = out_q.expired_tag;
  assign out_o.status       = out_q.status;
  assign out_o.last         = out_q.last;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_slot_q) < WHEEL_SLOTS)
    else $error("current slot out of range");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_RESULTS)
    else $error("too many expiries in one tick");

  a_expired_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.expired |-> !out_q.status)
    else $error("expired word carries a stop status");

  a_tick_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action == ACT_TICK |=> cur_slot_q != $past(cur_slot_q))
    else $error("tick did not advance the wheel");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_SCAN || state_q == ST_PUSH))
    else $error("held expiry outside a tick");

endmodule

@@ sim/hashed_timing_wheel_unit_tb.sv @@
// testbench for the timing wheel: table-driven directed words, then random traffic
`timescale 1ns / 1ps
module hashed_timing_wheel_unit_tb;
  import htw_pkg::*;

  localparam int unsigned NTIM  = 32;
  localparam int unsigned NSLOT = 300;

  typedef struct {
    logic [2:0]  action;
    logic [4:0]  id;
    logic [31:0] timeout;
    logic [15:0] kind;
    logic [31:0] tag;
    bit          has_exp;
    result_t     exp;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  htw_in_if  cmd_ch ();
  htw_out_if res_ch ();

  hashed_timing_wheel_unit #(.NUM_TIMERS(NTIM), .WHEEL_SLOTS(NSLOT)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [8:0]  wheel_pos;
  bit          armed [NTIM];
  logic [8:0]  due_slot [NTIM];
  logic [15:0] kind_mem [NTIM];
  logic [31:0] tag_mem [NTIM];
  logic [31:0] filed_at [NTIM];
  logic [31:0] file_count;
  bit          made [NTIM];

  result_t     pending_results[$];
  cmd_row_t    directed[$];
  int          fail_count = 0;
  bit          stim_done = 1'b0;
  int          hold_cycles = 0;

  function automatic result_t mk_res(bit ex, logic [4:0] id, logic [15:0] k,
                                     logic [31:0] t, bit st, bit lst);
    result_t r;
    r.expired = ex; r.expired_id = id; r.expired_type = k;
    r.expired_tag = t; r.status = st; r.last = lst;
    return r;
  endfunction

  function automatic void wheel_reset();
    wheel_pos = '0;
    file_count = '0;
    for (int i = 0; i < NTIM; i++) begin
      armed[i] = 1'b0; made[i] = 1'b0;
    end
  endfunction

  // apply one command to the wheel model and queue the words it causes
  function automatic void predict_wheel(cmd_row_t c);
    logic [31:0] nslots;
    logic [8:0]  nxt;
    bit          taken [NTIM];
    int          n;
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    bit          st;
    result_t     r;
    st = 1'b0;
    n = 0;
    if (c.action == ACT_TICK) begin
      nxt = 9'((wheel_pos + 1) % NSLOT);
      for (int i = 0; i < NTIM; i++) taken[i] = 1'b0;
      while (n < MAX_RESULTS) begin
        best = -1;
        best_age = '0;
        for (int i = 0; i < NTIM; i++) begin
          if (!armed[i] || taken[i] || due_slot[i] != nxt) continue;
          age = file_count - filed_at[i];
          if (best < 0 || age < best_age) begin
            best = i; best_age = age;
          end
        end
        if (best < 0) break;
        taken[best] = 1'b1;
        armed[best] = 1'b0;
        pending_results.push_back(mk_res(1, best[4:0], kind_mem[best], tag_mem[best], 0, 0));
        n++;
      end
      wheel_pos = nxt;
      if (n == 0) pending_results.push_back(mk_res(0, 0, 0, 0, 0, 1));
      else begin
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      return;
    end
    case (c.action)
      ACT_CREATE: begin
        kind_mem[c.id] = c.kind; tag_mem[c.id] = c.tag;
        armed[c.id] = 1'b0; made[c.id] = 1'b1;
      end
      ACT_START, ACT_RESTART: begin
        nslots = c.timeout / 2000 + 1;
        if (nslots < 3) nslots = 3;
        if (nslots > NSLOT) nslots = NSLOT - 2;
        due_slot[c.id] = 9'((32'(wheel_pos) + nslots) % NSLOT);
        filed_at[c.id] = file_count;
        file_count = file_count + 1;
        armed[c.id] = 1'b1;
      end
      ACT_STOP: begin
        if (armed[c.id]) armed[c.id] = 1'b0;
        else st = 1'b1;
      end
      default: ;
    endcase
    pending_results.push_back(mk_res(0, 0, 0, 0, st, 1));
  endfunction

  function automatic cmd_row_t row(logic [2:0] a, logic [4:0] id, logic [31:0] to,
                                   logic [15:0] k, logic [31:0] t);
    cmd_row_t c;
    c.action = a; c.id = id; c.timeout = to; c.kind = k; c.tag = t;
    c.has_exp = 1'b0; c.exp = '0;
    return c;
  endfunction

  function automatic cmd_row_t row_x(logic [2:0] a, logic [4:0] id, bit st);
    cmd_row_t c;
    c = row(a, id, 32'h0, 16'h0, 32'h0);
    c.has_exp = 1'b1;
    c.exp = mk_res(0, 0, 0, 0, st, 1);
    return c;
  endfunction

  // random command: mostly start/restart/tick on created timers
  function automatic cmd_row_t rand_cmd();
    cmd_row_t c;
    int p;
    int id;
    logic [31:0] to;
    p = $urandom_range(99);
    id = $urandom_range(NTIM - 1);
    case ($urandom_range(5))
      0: to = $urandom();
      1: to = $urandom_range(5999);
      2: to = $urandom_range(20000);
      default: to = $urandom_range(12000);
    endcase
    if (!made[id] || p < 8)
      c = row(ACT_CREATE, id[4:0], $urandom(), $urandom(), $urandom());
    else if (p < 30) c = row(ACT_START, id[4:0], to, $urandom(), $urandom());
    else if (p < 42) c = row(ACT_RESTART, id[4:0], to, $urandom(), $urandom());
    else if (p < 52) c = row(ACT_STOP, id[4:0], $urandom(), $urandom(), $urandom());
    else if (p < 55) c = row(3'($urandom_range(7, 5)), id[4:0], $urandom(), $urandom(),
                             $urandom());
    else c = row(ACT_TICK, id[4:0], $urandom(), $urandom(), $urandom());
    return c;
  endfunction

  task automatic send_word(cmd_row_t c);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.action     <= c.action;
    cmd_ch.timer_id   <= c.id;
    cmd_ch.timeout_ms <= c.timeout;
    cmd_ch.timer_type <= c.kind;
    cmd_ch.user_tag   <= c.tag;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    if (c.has_exp) begin
      predict_wheel(c);
      void'(pending_results.pop_back());
      pending_results.push_back(c.exp);
    end else begin
      predict_wheel(c);
    end
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  initial begin
    cmd_row_t c;
    int burst;
    cmd_ch.valid <= 1'b0;
    cmd_ch.action <= ACT_CREATE;
    cmd_ch.timer_id <= '0;
    cmd_ch.timeout_ms <= '0;
    cmd_ch.timer_type <= '0;
    cmd_ch.user_tag <= '0;
    wheel_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, stop of idle timer, bad action codes, ordering in one slot
    directed.push_back(row_x(ACT_TICK, 5'd0, 1'b0));
    directed.push_back(row_x(ACT_STOP, 5'd31, 1'b1));
    directed.push_back(row(ACT_CREATE, 5'd0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF));
    directed.push_back(row(ACT_CREATE, 5'd31, 32'hFFFF_FFFF, 16'h0, 32'h0));
    directed.push_back(row(ACT_CREATE, 5'd7, 32'h0, 16'hA5A5, 32'h5A5A_1234));
    directed.push_back(row_x(3'd5, 5'd3, 1'b0));
    directed.push_back(row_x(3'd7, 5'd31, 1'b0));
    directed.push_back(row(ACT_START, 5'd0, 32'h0, 16'h0, 32'h0));
    directed.push_back(row(ACT_RESTART, 5'd31, 32'd3999, 16'h0, 32'h0));
    directed.push_back(row(ACT_START, 5'd7, 32'd2000, 16'h0, 32'h0));
    directed.push_back(row(ACT_TICK, 5'd0, 32'h0, 16'h0, 32'h0));
    directed.push_back(row(ACT_TICK, 5'd0, 32'h0, 16'h0, 32'h0));
    directed.push_back(row(ACT_TICK, 5'd0, 32'h0, 16'h0, 32'h0));
    directed.push_back(row(ACT_START, 5'd0, 32'hFFFF_FFFF, 16'h0, 32'h0));
    directed.push_back(row(ACT_RESTART, 5'd0, 32'd4000, 16'h0, 32'h0));
    directed.push_back(row(ACT_STOP, 5'd0, 32'h0, 16'h0, 32'h0));
    directed.push_back(row_x(ACT_STOP, 5'd0, 1'b1));
    directed.push_back(row(ACT_START, 5'd31, 32'd597999, 16'h0, 32'h0));
    directed.push_back(row(ACT_START, 5'd7, 32'd599999, 16'h0, 32'h0));
    directed.push_back(row(ACT_START, 5'd0, 32'd6000, 16'h0, 32'h0));
    for (int i = 0; i < directed.size(); i++) send_word(directed[i]);

    // random: bursts with gaps
    for (int i = 0; i < 200; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && i < 200; b++, i++) begin
        c = rand_cmd();
        send_word(c);
      end
      idle_gap();
    end
    // keep the wheel turning so more timers come due
    for (int i = 0; i < 110; i++) send_word(row(ACT_TICK, 5'($urandom()), $urandom(),
                                                $urandom(), $urandom()));
    cmd_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern plus one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 400 && cyc < 700) begin
        hold_cycles++;
        res_ch.ready <= 1'b0;
      end else if (cyc % 97 < 40) res_ch.ready <= 1'b1;
      else res_ch.ready <= ($urandom_range(3) != 0);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (res_ch.expired !== e.expired) begin
          $error("expired exp %0d got %0d", e.expired, res_ch.expired); fail_count++;
        end
        if (res_ch.expired_id !== e.expired_id) begin
          $error("expired_id exp %0d got %0d", e.expired_id, res_ch.expired_id);
          fail_count++;
        end
        if (res_ch.expired_type !== e.expired_type) begin
          $error("expired_type exp %h got %h", e.expired_type, res_ch.expired_type);
          fail_count++;
        end
        if (res_ch.expired_tag !== e.expired_tag) begin
          $error("expired_tag exp %h got %h", e.expired_tag, res_ch.expired_tag);
          fail_count++;
        end
        if (res_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, res_ch.status); fail_count++;
        end
        if (res_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, res_ch.last); fail_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("hashed_timing_wheel_unit_tb: done, clean");
    else $display("hashed_timing_wheel_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("hashed_timing_wheel_unit_tb: done, errors");
    $finish;
  end

endmodule
